// ===== rtl/core/two_class_priority_queue_top_macros.svh =====
// Assertion helpers for the two-class priority queue.
`ifndef TWO_CLASS_PRIORITY_QUEUE_TOP_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TCPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TCPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tcpq_pkg.sv =====
`timescale 1ns / 1ps

package tcpq_pkg;

	localparam int ID_W   = 31;
	localparam int NAME_W = 16;
	localparam int OCNT_W = 7;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef enum logic [2:0] {
		ST_ENQUEUED   = 3'd0,
		ST_BAD_ID     = 3'd1,
		ST_EMPTY_NAME = 3'd2,
		ST_DUPLICATE  = 3'd3,
		ST_FULL       = 3'd4,
		ST_SERVED     = 3'd5,
		ST_EMPTY      = 3'd6
	} status_t;

	// One stored entry; the class is implied by the ring it sits in.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [NAME_W-1:0] name;
	} entry_t;

	// Per-ring commands from the sequencer.
	typedef struct packed {
		logic scan_start;  // read head entry, restart scan
		logic scan_step;   // read next entry after last one read
		logic push;        // write at tail
		logic pop;         // drop head
	} ring_ctl_t;

endpackage

// ===== rtl/core/tcpq_ring.sv =====
`timescale 1ns / 1ps

module tcpq_ring import tcpq_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int CNT_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ring_ctl_t        ctl,
	input  entry_t           wr_data,
	output entry_t           rd_data,
	output logic [CNT_W-1:0] count
);

	localparam int PTR_W = $clog2(DEPTH);

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] scan_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] rd_addr;
	entry_t           rd_q;
	entry_t           mem [DEPTH];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign rd_addr = ctl.scan_start ? head_q : ptr_next(scan_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			scan_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (ctl.scan_start || ctl.scan_step) begin
				scan_q <= rd_addr;
			end
			if (ctl.push) begin
				tail_q <= ptr_next(tail_q);
				cnt_q  <= cnt_q + CNT_W'(1);
			end else if (ctl.pop) begin
				head_q <= ptr_next(head_q);
				cnt_q  <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Entry storage, one write and one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q] <= wr_data;
		end
		if (ctl.scan_start || ctl.scan_step) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
	assign count   = cnt_q;

endmodule

// ===== rtl/core/two_class_priority_queue_top.sv =====
`timescale 1ns / 1ps

`include "two_class_priority_queue_top_macros.svh"

// Two-class priority queue. Holds up to QUEUE_DEPTH entries (positive 31-bit
// id, 16-bit name handle, priority bit). Priority entries are served before
// normal ones, each class in arrival order. Each accepted beat on the slave
// side is one command (enqueue or dequeue) and yields exactly one result beat
// on the master side carrying a status and the entry count after the command.
// Entries live in two ring memories, one per class, each with a registered
// read. A dequeue reads the head of the priority ring (or of the normal ring
// when no priority entry waits), pops it in a dequeue step and then goes to
// the emit step. An enqueue that passes the id and name checks scans both
// rings in parallel, one entry of each per cycle, for a duplicate id, then
// pushes or rejects the entry; rejected ids and names and a dequeue on an
// empty queue go straight to the emit step. One command is in work
// at a time; the result register lets the next command be accepted while the
// previous result is still waiting, and a result still held by a stalled
// master side adds its wait to the emit step of the next command.
// No clearing pass is needed after reset.
module two_class_priority_queue_top import tcpq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] cmd, [32:1] entry_id, [48:33] name_handle, [49] priority_req, [55:50] zero
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] status, [33:3] served_id, [49:34] served_name, [50] served_priority,
	// [57:51] entry_count, [63:58] zero
	output logic [63:0] m_tdata
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DEQ,
		S_SCAN,
		S_EMIT
	} state_t;

	state_t              state_q;
	logic [ID_W-1:0]     id_q;
	logic [NAME_W-1:0]   name_q;
	logic                prio_q;
	logic                src_prio_q;   // ring read for a dequeue
	logic [CNT_W-1:0]    k_q;          // scan reads issued so far
	logic                p_vld_s1;     // scan data in flight is a live entry
	logic                n_vld_s1;
	status_t             res_status_q;
	logic [ID_W-1:0]     res_id_q;
	logic [NAME_W-1:0]   res_name_q;
	logic                res_prio_q;
	logic [OCNT_W-1:0]   res_cnt_q;
	logic                m_tvalid_q;
	logic [63:0]         m_tdata_q;

	logic                accept;
	logic                in_cmd;
	logic signed [31:0]  in_id;
	logic [NAME_W-1:0]   in_name;
	logic                in_prio;
	logic                id_bad;
	logic [CNT_W-1:0]    p_cnt;
	logic [CNT_W-1:0]    n_cnt;
	logic [CNT_W-1:0]    total;
	logic                full;
	logic                hit;
	logic                more;
	logic                out_free;
	ring_ctl_t           p_ctl;
	ring_ctl_t           n_ctl;
	entry_t              wr_data;
	entry_t              p_rd;
	entry_t              n_rd;
	entry_t              deq_rd;

	assign in_cmd  = s_tdata[0];
	assign in_id   = s_tdata[32:1];
	assign in_name = s_tdata[48:33];
	assign in_prio = s_tdata[49];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign id_bad   = in_id[31] || (in_id == 32'sd0);

	assign total    = p_cnt + n_cnt;
	assign full     = (total >= CNT_W'(QUEUE_DEPTH));
	assign hit      = (p_vld_s1 && (p_rd.id == id_q)) || (n_vld_s1 && (n_rd.id == id_q));
	assign more     = (k_q < p_cnt) || (k_q < n_cnt);
	assign out_free = !m_tvalid_q || m_tready;
	assign deq_rd   = src_prio_q ? p_rd : n_rd;

	assign wr_data.id   = id_q;
	assign wr_data.name = name_q;

	// Ring commands follow the sequencer state.
	always_comb begin
		p_ctl = '0;
		n_ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_cmd == CMD_DEQ) begin
						if (p_cnt != '0) begin
							p_ctl.scan_start = 1'b1;
						end else if (n_cnt != '0) begin
							n_ctl.scan_start = 1'b1;
						end
					end else if (!id_bad && (in_name != '0)) begin
						p_ctl.scan_start = 1'b1;
						n_ctl.scan_start = 1'b1;
					end
				end
			end
			S_DEQ: begin
				p_ctl.pop = src_prio_q;
				n_ctl.pop = !src_prio_q;
			end
			S_SCAN: begin
				if (!hit) begin
					if (more) begin
						p_ctl.scan_step = 1'b1;
						n_ctl.scan_step = 1'b1;
					end else if (!full) begin
						p_ctl.push = prio_q;
						n_ctl.push = !prio_q;
					end
				end
			end
			S_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			id_q         <= '0;
			name_q       <= '0;
			prio_q       <= 1'b0;
			src_prio_q   <= 1'b0;
			k_q          <= '0;
			p_vld_s1     <= 1'b0;
			n_vld_s1     <= 1'b0;
			res_status_q <= ST_ENQUEUED;
			res_id_q     <= '0;
			res_name_q   <= '0;
			res_prio_q   <= 1'b0;
			res_cnt_q    <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			// a new result beat wins over the drain of the old one
			if ((state_q == S_EMIT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						id_q       <= in_id[ID_W-1:0];
						name_q     <= in_name;
						prio_q     <= in_prio;
						res_id_q   <= '0;
						res_name_q <= '0;
						res_prio_q <= 1'b0;
						res_cnt_q  <= OCNT_W'(total);
						if (in_cmd == CMD_DEQ) begin
							src_prio_q <= (p_cnt != '0);
							if (total == '0) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_EMIT;
							end else begin
								state_q <= S_DEQ;
							end
						end else if (id_bad) begin
							res_status_q <= ST_BAD_ID;
							state_q      <= S_EMIT;
						end else if (in_name == '0) begin
							res_status_q <= ST_EMPTY_NAME;
							state_q      <= S_EMIT;
						end else begin
							p_vld_s1 <= (p_cnt != '0);
							n_vld_s1 <= (n_cnt != '0);
							k_q      <= CNT_W'(1);
							state_q  <= S_SCAN;
						end
					end
				end
				S_DEQ: begin
					// head entry read last cycle; the pop lands this edge
					res_status_q <= ST_SERVED;
					res_id_q     <= deq_rd.id;
					res_name_q   <= deq_rd.name;
					res_prio_q   <= src_prio_q;
					res_cnt_q    <= OCNT_W'(total - CNT_W'(1));
					state_q      <= S_EMIT;
				end
				S_SCAN: begin
					if (hit) begin
						res_status_q <= ST_DUPLICATE;
						state_q      <= S_EMIT;
					end else if (more) begin
						p_vld_s1 <= (k_q < p_cnt);
						n_vld_s1 <= (k_q < n_cnt);
						k_q      <= k_q + CNT_W'(1);
					end else if (full) begin
						res_status_q <= ST_FULL;
						state_q      <= S_EMIT;
					end else begin
						res_status_q <= ST_ENQUEUED;
						res_cnt_q    <= OCNT_W'(total + CNT_W'(1));
						state_q      <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						m_tdata_q  <= {6'b0, res_cnt_q, res_prio_q, res_name_q, res_id_q,
							res_status_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	tcpq_ring #(
		.DEPTH (QUEUE_DEPTH),
		.CNT_W (CNT_W)
	) u_prio_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (p_ctl),
		.wr_data (wr_data),
		.rd_data (p_rd),
		.count   (p_cnt)
	);

	tcpq_ring #(
		.DEPTH (QUEUE_DEPTH),
		.CNT_W (CNT_W)
	) u_norm_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (n_ctl),
		.wr_data (wr_data),
		.rd_data (n_rd),
		.count   (n_cnt)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Both rings together never hold more than the depth.
	`TCPQ_ASSERT_NOW(a_total_bound, 1'b1, total <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
	// A write only happens with room left and only at scan end.
	`TCPQ_ASSERT_NOW(a_push_room, p_ctl.push || n_ctl.push, !full && state_q == S_SCAN,
		"push without room")
	// A served beat always carries a positive id.
	`TCPQ_ASSERT_NOW(a_served_id, m_tvalid && m_tdata[2:0] == ST_SERVED, m_tdata[33:3] != '0,
		"served id is zero")
	// A pop drops the total by one on the next edge.
	`TCPQ_ASSERT_NEXT(a_pop_count, p_ctl.pop || n_ctl.pop, total == $past(total) - CNT_W'(1),
		"pop count mismatch")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import tcpq_pkg::*;

	localparam int DEPTH       = 64;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_ITEMS = 85;
	localparam int HOLD_CYCLES = 300;
	localparam int NUM_DIRECTED = 22;

	// Command beat as driven on the slave side.
	typedef struct packed {
		logic        cmd;
		logic [31:0] entry_id;
		logic [15:0] name;
		logic        prio;
	} command_t;

	// Result beat fields as carried on the master side.
	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   id;
		logic [NAME_W-1:0] name;
		logic              prio;
		logic [6:0]        count;
	} result_t;

	typedef struct {
		logic [ID_W-1:0]   id;
		logic [NAME_W-1:0] name;
		logic              prio;
	} slot_t;

	// Directed row; fixed marks a row whose status and count are written out here.
	typedef struct packed {
		logic        cmd;
		logic [31:0] entry_id;
		logic [15:0] name;
		logic        prio;
		logic        fixed;
		status_t     status;
		logic [6:0]  count;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;

	slot_t   held_entries[$];
	result_t pending_results[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int dequeue_pct = 40;
	int hold_req = 0;
	int hold_left = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	int beats_in = 0;
	int status_seen[7];

	directed_row_t directed_rows[NUM_DIRECTED] = '{
		'{CMD_DEQ, 32'h0000_0000, 16'h0000, 1'b0, 1'b1, ST_EMPTY,      7'd0},
		'{CMD_ENQ, 32'h0000_0000, 16'h0001, 1'b0, 1'b1, ST_BAD_ID,     7'd0},
		'{CMD_ENQ, 32'h0000_0000, 16'h0000, 1'b1, 1'b1, ST_BAD_ID,     7'd0},
		'{CMD_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, ST_BAD_ID,     7'd0},
		'{CMD_ENQ, 32'h8000_0000, 16'h0001, 1'b0, 1'b1, ST_BAD_ID,     7'd0},
		'{CMD_ENQ, 32'h0000_0001, 16'h0000, 1'b1, 1'b1, ST_EMPTY_NAME, 7'd0},
		'{CMD_ENQ, 32'h7FFF_FFFF, 16'h0000, 1'b0, 1'b1, ST_EMPTY_NAME, 7'd0},
		'{CMD_ENQ, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, 1'b0, ST_ENQUEUED,   7'd0},
		'{CMD_ENQ, 32'h0000_0001, 16'h0001, 1'b1, 1'b0, ST_ENQUEUED,   7'd0},
		'{CMD_ENQ, 32'h7FFF_FFFF, 16'h1234, 1'b1, 1'b0, ST_ENQUEUED,   7'd0},
		'{CMD_ENQ, 32'h5555_5555, 16'hAAAA, 1'b0, 1'b0, ST_ENQUEUED,   7'd0},
		'{CMD_ENQ, 32'h2AAA_AAAA, 16'h5555, 1'b1, 1'b0, ST_ENQUEUED,   7'd0},
		'{CMD_ENQ, 32'h0000_0001, 16'h0002, 1'b0, 1'b0, ST_ENQUEUED,   7'd0},
		'{CMD_ENQ, 32'h0000_0002, 16'h0003, 1'b0, 1'b0, ST_ENQUEUED,   7'd0},
		'{CMD_DEQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, ST_SERVED,     7'd0},
		'{CMD_ENQ, 32'h0000_0003, 16'h0004, 1'b1, 1'b0, ST_ENQUEUED,   7'd0},
		'{CMD_DEQ, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, ST_SERVED,     7'd0},
		'{CMD_DEQ, 32'h8000_0000, 16'h8000, 1'b0, 1'b0, ST_SERVED,     7'd0},
		'{CMD_DEQ, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, ST_SERVED,     7'd0},
		'{CMD_DEQ, 32'h0000_0000, 16'h0000, 1'b1, 1'b0, ST_SERVED,     7'd0},
		'{CMD_DEQ, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, ST_SERVED,     7'd0},
		'{CMD_DEQ, 32'h1234_5678, 16'h4321, 1'b1, 1'b0, ST_EMPTY,      7'd0}
	};

	two_class_priority_queue_top #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Queue predictor: applies one command to the held entries and returns the result.
	function automatic result_t apply_command(command_t c);
		result_t r;
		slot_t   e;
		bit      dup;
		int      pos;
		r = '0;
		dup = 1'b0;
		pos = 0;
		if (c.cmd == CMD_DEQ) begin
			if (held_entries.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.status = ST_SERVED;
				r.id = held_entries[0].id;
				r.name = held_entries[0].name;
				r.prio = held_entries[0].prio;
				void'(held_entries.pop_front());
			end
		end else if (c.entry_id == 32'd0 || c.entry_id[31]) begin
			r.status = ST_BAD_ID;
		end else if (c.name == '0) begin
			r.status = ST_EMPTY_NAME;
		end else begin
			foreach (held_entries[i])
				if (held_entries[i].id == c.entry_id[30:0])
					dup = 1'b1;
			if (dup) begin
				r.status = ST_DUPLICATE;
			end else if (held_entries.size() >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// priority entries go after the last priority entry, normal ones at the tail
				if (c.prio) begin
					while (pos < held_entries.size() && held_entries[pos].prio)
						pos++;
				end else begin
					pos = held_entries.size();
				end
				e.id = c.entry_id[30:0];
				e.name = c.name;
				e.prio = c.prio;
				held_entries.insert(pos, e);
				r.status = ST_ENQUEUED;
			end
		end
		r.count = 7'(held_entries.size());
		return r;
	endfunction

	// Mostly well-formed traffic; a few beats of raw noise.
	function automatic command_t random_command();
		command_t c;
		int       pick;
		pick = $urandom_range(99);
		c.cmd = CMD_ENQ;
		c.entry_id = $urandom;
		c.name = 16'($urandom);
		c.prio = 1'($urandom_range(1));
		if (pick < 8) begin
			c.cmd = 1'($urandom_range(1));
			if ($urandom_range(3) == 0)
				c.name = '0;
		end else if ($urandom_range(99) < dequeue_pct || held_entries.size() > 58) begin
			c.cmd = CMD_DEQ;
		end else begin
			c.name = 16'($urandom_range(65535, 1));
			if (held_entries.size() > 0 && $urandom_range(9) == 0)
				c.entry_id = {1'b0, held_entries[$urandom_range(held_entries.size() - 1)].id};
			else if ($urandom_range(3) == 0)
				c.entry_id = $urandom_range(32'h7FFF_FFFF, 1);
			else
				c.entry_id = $urandom_range(400, 1);
		end
		return c;
	endfunction

	// Drive one command beat; predict its result once it is taken.
	task automatic send_command(command_t c, bit fixed, status_t st, logic [6:0] cnt);
		result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, c.prio, c.name, c.entry_id, c.cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		beats_in++;
		r = apply_command(c);
		if (fixed) begin
			// only rejects and empty reads are written out; those leave no served fields
			r = '0;
			r.status = st;
			r.count = cnt;
		end
		pending_results.push_back(r);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls, or a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Result checker: each beat against the oldest prediction.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = status_t'(m_tdata[2:0]);
			got.id = m_tdata[33:3];
			got.name = m_tdata[49:34];
			got.prio = m_tdata[50];
			got.count = m_tdata[57:51];
			if (m_tdata[2:0] < 3'd7)
				status_seen[m_tdata[2:0]]++;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: result beat with nothing expected, data %h", $realtime, m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.id !== want.id || got.name !== want.name
						|| got.prio !== want.prio || got.count !== want.count) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: mismatch exp st=%0d id=%h nm=%h pr=%b cnt=%0d, got st=%0d id=%h nm=%h pr=%b cnt=%0d",
							$realtime, want.status, want.id, want.name, want.prio, want.count,
							m_tdata[2:0], got.id, got.name, got.prio, got.count);
				end
			end
		end
	end

	// Watchdog on cycles with no beat moving on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no beat for %0d cycles, %0d results outstanding",
					QUIET_LIMIT, pending_results.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		command_t c;
		int       base_id;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			c.cmd = directed_rows[i].cmd;
			c.entry_id = directed_rows[i].entry_id;
			c.name = directed_rows[i].name;
			c.prio = directed_rows[i].prio;
			send_command(c, directed_rows[i].fixed, directed_rows[i].status,
				directed_rows[i].count);
		end

		// random phases: none, sender gaps, receiver stalls, both
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 48 : (phase == 3) ? 27 : 0;
			stall_pct     = (phase == 2) ? 48 : (phase == 3) ? 27 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 30 == 0)
					dequeue_pct = 25 + 20 * $urandom_range(2);
				send_command(random_command(), 1'b0, ST_ENQUEUED, 7'd0);
			end

			if (phase == 1) begin
				// sender waits for every result, then the receiver holds off while
				// enqueues keep coming: the queue fills, hits full, and input stalls
				send_idle_pct = 0;
				stall_pct = 0;
				wait_drained();
				hold_req = HOLD_CYCLES;
				base_id = 32'h0010_0000;
				for (int n = 0; n < DEPTH + 8; n++) begin
					c.cmd = CMD_ENQ;
					c.entry_id = base_id + n;
					c.name = 16'($urandom_range(65535, 1));
					c.prio = 1'($urandom_range(1));
					send_command(c, 1'b0, ST_ENQUEUED, 7'd0);
				end
				// reject order while full: bad id, empty name, duplicate come before full
				c.entry_id = 32'h0;
				send_command(c, 1'b0, ST_ENQUEUED, 7'd0);
				c.entry_id = base_id + 1;
				c.name = '0;
				send_command(c, 1'b0, ST_ENQUEUED, 7'd0);
				c.name = 16'hBEEF;
				send_command(c, 1'b0, ST_ENQUEUED, 7'd0);
				c.cmd = CMD_DEQ;
				for (int n = 0; n < DEPTH + 4; n++)
					send_command(c, 1'b0, ST_ENQUEUED, 7'd0);
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Covered %0d command beats: %0d enqueued, %0d served, %0d empty reads,",
			beats_in, status_seen[ST_ENQUEUED], status_seen[ST_SERVED], status_seen[ST_EMPTY]);
		$display("  rejects: %0d bad id, %0d empty name, %0d duplicate, %0d full; %0d errors",
			status_seen[ST_BAD_ID], status_seen[ST_EMPTY_NAME], status_seen[ST_DUPLICATE],
			status_seen[ST_FULL], fail_count);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
